// ----- rtl/hrdp_pkg.sv -----
// ----------------------------------------------------------------------------
// HID report descriptor parser package
// Item codes, queue entry types and helper functions shared by the parser.
// ----------------------------------------------------------------------------
package hrdp_pkg;

  // Item types from the prefix byte.
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // Size code that stands for four data bytes.
  localparam logic [1:0] SIZE_CODE_4B = 2'd3;

  // Item tags.
  localparam logic [3:0] TAG_USAGE_PAGE     = 4'h0;
  localparam logic [3:0] TAG_REPORT_SIZE    = 4'h7;
  localparam logic [3:0] TAG_REPORT_COUNT   = 4'h9;
  localparam logic [3:0] TAG_USAGE          = 4'h0;
  localparam logic [3:0] TAG_INPUT          = 4'h8;
  localparam logic [3:0] TAG_COLLECTION     = 4'hA;
  localparam logic [3:0] TAG_END_COLLECTION = 4'hC;

  // Record kinds.
  localparam logic KIND_COLLECTION = 1'b0;
  localparam logic KIND_SUMMARY    = 1'b1;

  localparam int ITEMQ_DEPTH = 2;
  localparam int OUTQ_DEPTH  = 4;
  localparam int MAX_EMIT    = 3;

  // One decoded item, or an end-of-descriptor marker, from front to back.
  typedef struct packed {
    logic        exec;
    logic        last;
    logic [3:0]  tag;
    logic [1:0]  kind;
    logic [31:0] data;
  } item_t;

  // One result record.
  typedef struct packed {
    logic        kind;
    logic [7:0]  num;
    logic [15:0] page;
    logic [15:0] usage;
    logic [29:0] len;
    logic [7:0]  total;
    logic        eor;
  } result_t;

  // Input bit count rounded up to bytes, plus one; zero if no bits.
  function automatic logic [29:0] len_of(input logic [31:0] bits);
    logic [29:0] b;
    b = 30'((33'(bits) + 33'd7) >> 3);
    return (b == 30'd0) ? 30'd0 : b + 30'd1;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ----- rtl/hrdp_front.sv -----
// ----------------------------------------------------------------------------
// HID parser front end
// Splits the byte stream into short items and assembles their data.
// ----------------------------------------------------------------------------
module hrdp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  input  logic [7:0]     byte_data,
  input  logic           byte_last,
  output logic           push,
  output hrdp_pkg::item_t push_item
);
  import hrdp_pkg::*;

  logic [2:0]  bytes_pending, bytes_pending_next;
  logic [3:0]  item_tag, item_tag_next;
  logic [1:0]  item_type, item_type_next;
  logic [31:0] data_accum, data_accum_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic        exec;

  always_comb begin
    bytes_pending_next = bytes_pending;
    item_tag_next      = item_tag;
    item_type_next     = item_type;
    data_accum_next    = data_accum;
    byte_pos_next      = byte_pos;
    exec               = 1'b0;
    if (byte_valid) begin
      if (bytes_pending == 3'd0) begin
        item_tag_next   = byte_data[7:4];
        item_type_next  = byte_data[3:2];
        data_accum_next = 32'd0;
        byte_pos_next   = 2'd0;
        if (byte_data[1:0] == SIZE_CODE_4B) begin
          bytes_pending_next = 3'd4;
        end else begin
          bytes_pending_next = {1'b0, byte_data[1:0]};
        end
        exec = (byte_data[1:0] == 2'd0);
      end else begin
        data_accum_next    = data_accum | (32'(byte_data) << {byte_pos, 3'b000});
        byte_pos_next      = byte_pos + 2'd1;
        bytes_pending_next = bytes_pending - 3'd1;
        exec               = (bytes_pending == 3'd1);
      end
    end
    push           = byte_valid && (exec || byte_last);
    push_item.exec = exec;
    push_item.last = byte_last;
    push_item.tag  = item_tag_next;
    push_item.kind = item_type_next;
    push_item.data = data_accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_valid && byte_last)) begin
      bytes_pending <= 3'd0;
      item_tag      <= 4'd0;
      item_type     <= 2'd0;
      data_accum    <= 32'd0;
      byte_pos      <= 2'd0;
    end else begin
      bytes_pending <= bytes_pending_next;
      item_tag      <= item_tag_next;
      item_type     <= item_type_next;
      data_accum    <= data_accum_next;
      byte_pos      <= byte_pos_next;
    end
  end

endmodule

// ----- rtl/hrdp_itemq.sv -----
// ----------------------------------------------------------------------------
// HID parser item queue
// Two-entry queue of decoded items between the front and back ends.
// ----------------------------------------------------------------------------
module hrdp_itemq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hrdp_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output hrdp_pkg::item_t head_item,
  input  logic            pop
);
  import hrdp_pkg::*;

  localparam int PW = $clog2(ITEMQ_DEPTH);

  item_t         ent [ITEMQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full       = (count == (PW+1)'(ITEMQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- rtl/hrdp_back.sv -----
// ----------------------------------------------------------------------------
// HID parser back end
// Carries out decoded items: globals, usage, collections and records.
// ----------------------------------------------------------------------------
module hrdp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  hrdp_pkg::item_t   head_item,
  input  logic              out_room,
  output logic              pop,
  output logic [1:0]        emit_count,
  output hrdp_pkg::result_t emit [hrdp_pkg::MAX_EMIT]
);
  import hrdp_pkg::*;

  logic [15:0] rep_size, rep_size_next;
  logic [15:0] rep_count, rep_count_next;
  logic [31:0] prod, prod_next;
  logic [15:0] cur_page, cur_page_next;
  logic [15:0] cur_usage, cur_usage_next;
  logic [7:0]  nest_depth, nest_depth_next;
  logic        coll_open, coll_open_next;
  logic [15:0] coll_page, coll_page_next;
  logic [15:0] coll_usage, coll_usage_next;
  logic [31:0] coll_max_bits, coll_max_bits_next;
  logic [31:0] best_bits, best_bits_next;
  logic [15:0] first_page, first_page_next;
  logic [15:0] first_usage, first_usage_next;
  logic [7:0]  coll_seen, coll_seen_next;

  assign pop = head_valid && out_room;

  always_comb begin
    logic [1:0] n;
    n                  = 2'd0;
    rep_size_next      = rep_size;
    rep_count_next     = rep_count;
    cur_page_next      = cur_page;
    cur_usage_next     = cur_usage;
    nest_depth_next    = nest_depth;
    coll_open_next     = coll_open;
    coll_page_next     = coll_page;
    coll_usage_next    = coll_usage;
    coll_max_bits_next = coll_max_bits;
    best_bits_next     = best_bits;
    first_page_next    = first_page;
    first_usage_next   = first_usage;
    coll_seen_next     = coll_seen;
    for (int i = 0; i < MAX_EMIT; i++) begin
      emit[i] = '0;
    end

    if (pop && head_item.exec) begin
      case (head_item.kind)
        TYPE_GLOBAL: begin
          if (head_item.tag == TAG_USAGE_PAGE) begin
            cur_page_next = head_item.data[15:0];
          end else if (head_item.tag == TAG_REPORT_SIZE) begin
            rep_size_next = sat16(head_item.data);
          end else if (head_item.tag == TAG_REPORT_COUNT) begin
            rep_count_next = sat16(head_item.data);
          end
        end
        TYPE_LOCAL: begin
          if (head_item.tag == TAG_USAGE) begin
            cur_usage_next = head_item.data[15:0];
          end
        end
        TYPE_MAIN: begin
          if (head_item.tag == TAG_COLLECTION) begin
            if (nest_depth == 8'd0) begin
              // A record still open at the outer level is closed first.
              if (coll_open) begin
                emit[n] = '{KIND_COLLECTION,
                            (coll_seen != 8'd0) ? coll_seen - 8'd1 : 8'd0,
                            coll_page, coll_usage, len_of(coll_max_bits),
                            coll_seen, 1'b0};
                n = n + 2'd1;
              end
              if (coll_seen == 8'd0) begin
                first_page_next  = cur_page;
                first_usage_next = cur_usage;
              end
              if (coll_seen != 8'hFF) begin
                coll_seen_next = coll_seen + 8'd1;
              end
              coll_open_next     = 1'b1;
              coll_page_next     = cur_page;
              coll_usage_next    = cur_usage;
              coll_max_bits_next = 32'd0;
            end
            if (nest_depth != 8'hFF) begin
              nest_depth_next = nest_depth + 8'd1;
            end
          end else if (head_item.tag == TAG_END_COLLECTION) begin
            if (nest_depth != 8'd0) begin
              nest_depth_next = nest_depth - 8'd1;
            end
            if (nest_depth_next == 8'd0) begin
              if (coll_open) begin
                emit[n] = '{KIND_COLLECTION,
                            (coll_seen != 8'd0) ? coll_seen - 8'd1 : 8'd0,
                            coll_page, coll_usage, len_of(coll_max_bits),
                            coll_seen, 1'b0};
                n = n + 2'd1;
              end
              coll_open_next     = 1'b0;
              coll_max_bits_next = 32'd0;
            end
          end else if (head_item.tag == TAG_INPUT) begin
            if (prod > best_bits) begin
              best_bits_next = prod;
            end
            if (prod > coll_max_bits) begin
              coll_max_bits_next = prod;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (pop && head_item.last) begin
      // Close any open record, then the summary; everything starts over.
      if (coll_open_next) begin
        emit[n] = '{KIND_COLLECTION,
                    (coll_seen_next != 8'd0) ? coll_seen_next - 8'd1 : 8'd0,
                    coll_page_next, coll_usage_next, len_of(coll_max_bits_next),
                    coll_seen_next, 1'b0};
        n = n + 2'd1;
      end
      emit[n] = '{KIND_SUMMARY, 8'd0,
                  (coll_seen_next != 8'd0) ? first_page_next : 16'd0,
                  (coll_seen_next != 8'd0) ? first_usage_next : 16'd0,
                  len_of(best_bits_next), coll_seen_next, 1'b1};
      n = n + 2'd1;
      rep_size_next      = 16'd0;
      rep_count_next     = 16'd0;
      cur_page_next      = 16'd0;
      cur_usage_next     = 16'd0;
      nest_depth_next    = 8'd0;
      coll_open_next     = 1'b0;
      coll_page_next     = 16'd0;
      coll_usage_next    = 16'd0;
      coll_max_bits_next = 32'd0;
      best_bits_next     = 32'd0;
      first_page_next    = 16'd0;
      first_usage_next   = 16'd0;
      coll_seen_next     = 8'd0;
    end

    emit_count = n;
    // The product is registered so that the Input compare sees it next cycle.
    prod_next  = 32'(rep_size_next) * 32'(rep_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_size      <= 16'd0;
      rep_count     <= 16'd0;
      prod          <= 32'd0;
      cur_page      <= 16'd0;
      cur_usage     <= 16'd0;
      nest_depth    <= 8'd0;
      coll_open     <= 1'b0;
      coll_page     <= 16'd0;
      coll_usage    <= 16'd0;
      coll_max_bits <= 32'd0;
      best_bits     <= 32'd0;
      first_page    <= 16'd0;
      first_usage   <= 16'd0;
      coll_seen     <= 8'd0;
    end else begin
      rep_size      <= rep_size_next;
      rep_count     <= rep_count_next;
      prod          <= prod_next;
      cur_page      <= cur_page_next;
      cur_usage     <= cur_usage_next;
      nest_depth    <= nest_depth_next;
      coll_open     <= coll_open_next;
      coll_page     <= coll_page_next;
      coll_usage    <= coll_usage_next;
      coll_max_bits <= coll_max_bits_next;
      best_bits     <= best_bits_next;
      first_page    <= first_page_next;
      first_usage   <= first_usage_next;
      coll_seen     <= coll_seen_next;
    end
  end

`ifndef SYNTH
  // A record is open exactly while the parser is inside a collection.
  assert property (@(posedge clk) disable iff (rst) coll_open == (nest_depth != 8'd0))
    else $error("collection open flag disagrees with nesting depth");

  // Normal nesting never produces more than two records from one item.
  assert property (@(posedge clk) disable iff (rst) emit_count != 2'd3)
    else $error("three records emitted from one item");

  // The product register tracks the report size and count.
  assert property (@(posedge clk) disable iff (rst)
                   prod == 32'(rep_size) * 32'(rep_count))
    else $error("product register out of step with report size and count");

  // The first collection's usages hold until the descriptor ends.
  assert property (@(posedge clk) disable iff (rst)
                   (coll_seen != 8'd0) && !(pop && head_item.last)
                   |=> $stable(first_page) && $stable(first_usage))
    else $error("first collection usage changed mid descriptor");
`endif

endmodule

// ----- rtl/hrdp_outq.sv -----
// ----------------------------------------------------------------------------
// HID parser result queue
// Four-entry output queue that takes up to three records in one cycle.
// ----------------------------------------------------------------------------
module hrdp_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        emit_count,
  input  hrdp_pkg::result_t emit [hrdp_pkg::MAX_EMIT],
  output logic              room,
  output logic              out_valid,
  output hrdp_pkg::result_t out_item,
  input  logic              out_ready
);
  import hrdp_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);

  result_t       ent [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          out_take;

  // Accept new records only when a full burst is sure to fit.
  assign room      = (count <= (PW+1)'(OUTQ_DEPTH - MAX_EMIT));
  assign out_valid = (count != '0);
  assign out_item  = ent[rd_ptr];
  assign out_take  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_EMIT; i++) begin
      if (2'(i) < emit_count) begin
        ent[wr_ptr + PW'(i)] <= emit[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(emit_count);
      if (out_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(emit_count) - (PW+1)'(out_take);
    end
  end

endmodule

// ----- rtl/hid_report_descriptor_parser.sv -----
// ----------------------------------------------------------------------------
// HID report descriptor parser
// Decodes short items of a report descriptor and reports top-level collections.
// ----------------------------------------------------------------------------
// Throughput: one descriptor byte per cycle while the result side keeps up.
// A record reaches m_axis from the byte that completes its item through the
// item queue and then the result queue, each of which registers it.
// The result queue pauses the back end when it could not take a full burst.
// Reset: synchronous, active high; all state clears at once, expecting a prefix.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser (
  input  logic        clk,
  input  logic        rst,
  // Descriptor byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] desc_byte
  input  logic        s_axis_tlast,   // final_byte
  // Result records.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] coll_number, [23:8] usage_page_out, [39:24] usage_out,
  // [69:40] input_len_bytes, [77:70] coll_total, [79:78] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,   // record_kind
  output logic        m_axis_tlast    // end_of_run
);
  import hrdp_pkg::*;

  // The front end sees every accepted byte. It forwards a request to the
  // item queue for each completed item and for the last byte of a
  // descriptor, which carries the end-of-descriptor flag even when the
  // item under assembly is dropped.
  logic    byte_accept;
  logic    push;
  item_t   push_item;
  logic    itemq_full;
  logic    head_valid;
  item_t   head_item;
  logic    pop;

  // The back end writes up to three records into the result queue at once.
  logic [1:0] emit_count;
  result_t    emit [MAX_EMIT];
  logic       out_room;
  result_t    out_item;

  assign s_axis_tready = !itemq_full;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  hrdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_accept),
    .byte_data  (s_axis_tdata),
    .byte_last  (s_axis_tlast),
    .push       (push),
    .push_item  (push_item)
  );

  hrdp_itemq u_itemq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (itemq_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // Global and local state, collection tracking and the size-times-count
  // product live here. Each queue entry is carried out as it is popped.
  hrdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .out_room   (out_room),
    .pop        (pop),
    .emit_count (emit_count),
    .emit       (emit)
  );

  hrdp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .emit_count (emit_count),
    .emit       (emit),
    .room       (out_room),
    .out_valid  (m_axis_tvalid),
    .out_item   (out_item),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, out_item.total, out_item.len, out_item.usage,
                         out_item.page, out_item.num};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.eor;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID report descriptor parser testbench
// Sends directed, saturating and random report descriptors one byte at a time.
// A model of the parser predicts every collection record and summary, and
// each record that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import hrdp_pkg::*;

  // Stimulus stops once this many descriptor bytes have been sent.
  localparam int BYTE_GOAL      = 1700;
  // Cycles without any accepted request before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to wait after the last expected record, well above the latency.
  localparam int DRAIN_CYCLES   = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  always #5 clk = ~clk;

  hid_report_descriptor_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  // --------------------------------------------------------------------------
  // Parser model. It mirrors the parse state of the block and appends every
  // record that a byte causes to expected_records.
  // --------------------------------------------------------------------------
  logic [2:0]  ps_pending;      // data bytes still to come, 0 means prefix next
  logic [3:0]  ps_tag;
  logic [1:0]  ps_type;
  logic [31:0] ps_data;
  logic [1:0]  ps_pos;
  logic [15:0] ps_rsize;
  logic [15:0] ps_rcount;
  logic [15:0] ps_page;
  logic [15:0] ps_usage;
  logic [7:0]  ps_depth;
  logic        ps_open;
  logic [15:0] ps_open_page;
  logic [15:0] ps_open_usage;
  logic [31:0] ps_open_bits;
  logic [31:0] ps_peak_bits;
  logic [15:0] ps_first_page;
  logic [15:0] ps_first_usage;
  logic [7:0]  ps_colls;

  result_t expected_records[$];

  // Bookkeeping for the summary and the final verdict.
  int errors            = 0;
  int bytes_sent        = 0;
  int descriptors_sent  = 0;
  int records_checked   = 0;
  int summaries_checked = 0;
  int quiet_cycles      = 0;
  int rcv_stall         = 0;
  bit snd_idle          = 1'b1;
  bit rcv_idle          = 1'b1;

  // Descriptor under construction.
  logic [7:0] desc_q[$];

  // Adds one byte at the end of the descriptor under construction.
  function automatic void append_byte(input logic [7:0] b);
    desc_q = {desc_q, b};
  endfunction

  function automatic void clear_parser_model();
    ps_pending     = 3'd0;
    ps_tag         = 4'd0;
    ps_type        = 2'd0;
    ps_data        = 32'd0;
    ps_pos         = 2'd0;
    ps_rsize       = 16'd0;
    ps_rcount      = 16'd0;
    ps_page        = 16'd0;
    ps_usage       = 16'd0;
    ps_depth       = 8'd0;
    ps_open        = 1'b0;
    ps_open_page   = 16'd0;
    ps_open_usage  = 16'd0;
    ps_open_bits   = 32'd0;
    ps_peak_bits   = 32'd0;
    ps_first_page  = 16'd0;
    ps_first_usage = 16'd0;
    ps_colls       = 8'd0;
  endfunction

  // Report length in bytes: the bit count rounded up to bytes plus a report
  // ID byte, or zero when there are no input bits at all.
  function automatic logic [29:0] bytes_for_bits(input logic [31:0] bits);
    logic [32:0] whole;
    whole = ({1'b0, bits} + 33'd7) >> 3;
    if (whole == 33'd0) return 30'd0;
    return whole[29:0] + 30'd1;
  endfunction

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void push_record(input logic kind, input logic [7:0] num,
                                      input logic [15:0] page,
                                      input logic [15:0] usage,
                                      input logic [29:0] len);
    result_t r;
    r.kind  = kind;
    r.num   = num;
    r.page  = page;
    r.usage = usage;
    r.len   = len;
    r.total = ps_colls;
    r.eor   = (kind == KIND_SUMMARY);
    expected_records = {expected_records, r};
  endfunction

  // Emits the open top-level collection, if there is one, and forgets it.
  function automatic void close_collection();
    if (ps_open)
      push_record(KIND_COLLECTION, (ps_colls != 8'd0) ? ps_colls - 8'd1 : 8'd0,
                  ps_open_page, ps_open_usage, bytes_for_bits(ps_open_bits));
    ps_open      = 1'b0;
    ps_open_bits = 32'd0;
  endfunction

  // Acts on a complete item. Anything not listed here is consumed and ignored.
  function automatic void execute_item();
    logic [31:0] bits;
    case (ps_type)
      TYPE_GLOBAL: begin
        if (ps_tag == TAG_USAGE_PAGE)        ps_page   = ps_data[15:0];
        else if (ps_tag == TAG_REPORT_SIZE)  ps_rsize  = clamp16(ps_data);
        else if (ps_tag == TAG_REPORT_COUNT) ps_rcount = clamp16(ps_data);
      end
      TYPE_LOCAL: begin
        // Usage stays in force across main items.
        if (ps_tag == TAG_USAGE) ps_usage = ps_data[15:0];
      end
      TYPE_MAIN: begin
        if (ps_tag == TAG_COLLECTION) begin
          if (ps_depth == 8'd0) begin
            close_collection();
            if (ps_colls == 8'd0) begin
              ps_first_page  = ps_page;
              ps_first_usage = ps_usage;
            end
            if (ps_colls != 8'hFF) ps_colls = ps_colls + 8'd1;
            ps_open       = 1'b1;
            ps_open_page  = ps_page;
            ps_open_usage = ps_usage;
            ps_open_bits  = 32'd0;
          end
          if (ps_depth != 8'hFF) ps_depth = ps_depth + 8'd1;
        end else if (ps_tag == TAG_END_COLLECTION) begin
          if (ps_depth != 8'd0) ps_depth = ps_depth - 8'd1;
          if (ps_depth == 8'd0) close_collection();
        end else if (ps_tag == TAG_INPUT) begin
          bits = {16'd0, ps_rsize} * {16'd0, ps_rcount};
          if (bits > ps_peak_bits) ps_peak_bits = bits;
          if (bits > ps_open_bits) ps_open_bits = bits;
        end
      end
      default: ;
    endcase
  endfunction

  // Feeds one accepted descriptor byte to the model.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    logic [2:0] nbytes;
    if (ps_pending == 3'd0) begin
      ps_tag  = b[7:4];
      ps_type = b[3:2];
      ps_data = 32'd0;
      ps_pos  = 2'd0;
      nbytes  = (b[1:0] == SIZE_CODE_4B) ? 3'd4 : {1'b0, b[1:0]};
      if (nbytes == 3'd0) execute_item();
      else ps_pending = nbytes;
    end else begin
      ps_data    = ps_data | ({24'd0, b} << {ps_pos, 3'b000});
      ps_pos     = ps_pos + 2'd1;
      ps_pending = ps_pending - 3'd1;
      if (ps_pending == 3'd0) execute_item();
    end
    // The last byte drops an unfinished item, closes an open collection,
    // reports the descriptor as a whole and starts over from reset.
    if (last) begin
      close_collection();
      push_record(KIND_SUMMARY, 8'd0,
                  (ps_colls != 8'd0) ? ps_first_page : 16'd0,
                  (ps_colls != 8'd0) ? ps_first_usage : 16'd0,
                  bytes_for_bits(ps_peak_bits));
      clear_parser_model();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls on tready and a field-by-field compare of each
  // accepted record against the oldest prediction.
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_record();
    result_t want;
    if (expected_records.size() == 0) begin
      $error("record with no prediction waiting: tdata %h tuser %b tlast %b",
             m_tdata, m_tuser, m_tlast);
      errors++;
      return;
    end
    want = expected_records.pop_front();
    compare_field("record_kind", 32'(want.kind), 32'(m_tuser));
    compare_field("coll_number", 32'(want.num), 32'(m_tdata[7:0]));
    compare_field("usage_page_out", 32'(want.page), 32'(m_tdata[23:8]));
    compare_field("usage_out", 32'(want.usage), 32'(m_tdata[39:24]));
    compare_field("input_len_bytes", 32'(want.len), 32'(m_tdata[69:40]));
    compare_field("coll_total", 32'(want.total), 32'(m_tdata[77:70]));
    compare_field("tdata_pad", 32'd0, 32'(m_tdata[79:78]));
    compare_field("end_of_run", 32'(want.eor), 32'(m_tlast));
    records_checked++;
    if (want.kind == KIND_SUMMARY) summaries_checked++;
  endfunction

  // After each record a fresh stall is drawn; while the bus is empty, tready
  // is now and then dropped as well, so that a new record can meet a stall.
  always @(posedge clk) begin
    if (rst) begin
      rcv_stall = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_record();
        rcv_stall = rcv_idle ? $urandom_range(0, 6) : 0;
      end else if (!m_tvalid && rcv_idle && rcv_stall == 0 && $urandom_range(0, 3) == 0)
        rcv_stall = $urandom_range(1, 6);
      if (rcv_stall > 0) begin
        rcv_stall = rcv_stall - 1;
        m_tready <= 1'b0;
      end else
        m_tready <= 1'b1;
    end
  end

  // Watchdog: any accepted request on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d records still expected",
                 quiet_cycles, expected_records.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Sends one byte, after a random gap when the sender idles. tvalid stays
  // high from one byte to the next when no gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = snd_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  // Sends desc_q as one descriptor, with tlast on its final byte.
  task automatic send_descriptor();
    int i;
    for (i = 0; i < desc_q.size(); i++)
      send_byte(desc_q[i], i == desc_q.size() - 1);
    descriptors_sent++;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'h0000_FFFF;
          2:       return 32'h0001_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // Appends one short item with a random size code; the data bytes carry the
  // low bytes of value, little-endian.
  function automatic void add_item(input logic [3:0] tag, input logic [1:0] itype,
                                   input logic [31:0] value);
    logic [1:0] code;
    int nbytes;
    int k;
    case ($urandom_range(0, 7))
      0:          code = 2'd0;
      1, 2, 3, 4: code = 2'd1;
      5, 6:       code = 2'd2;
      default:    code = SIZE_CODE_4B;
    endcase
    nbytes = (code == SIZE_CODE_4B) ? 4 : int'(code);
    append_byte({tag, itype, code});
    for (k = 0; k < nbytes; k++) append_byte(value[8*k +: 8]);
  endfunction

  // A mostly well-formed descriptor with random content. Now and then the
  // open collections are left open, and now and then the descriptor is cut
  // short, possibly in the middle of an item.
  function automatic void build_structured_descriptor();
    int depth;
    int n;
    int i;
    int cut;
    depth = 0;
    n = $urandom_range(1, 40);
    desc_q.delete();
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0, 1:     add_item(TAG_USAGE_PAGE, TYPE_GLOBAL, random_value());
        2, 3:     add_item(TAG_USAGE, TYPE_LOCAL, random_value());
        4, 5:     add_item(TAG_REPORT_SIZE, TYPE_GLOBAL, random_value());
        6, 7:     add_item(TAG_REPORT_COUNT, TYPE_GLOBAL, random_value());
        8, 9, 10: add_item(TAG_INPUT, TYPE_MAIN, random_value());
        11, 12: begin
          add_item(TAG_COLLECTION, TYPE_MAIN, random_value());
          depth++;
        end
        13, 14: begin
          // At depth zero this becomes a stray End Collection.
          add_item(TAG_END_COLLECTION, TYPE_MAIN, random_value());
          if (depth > 0) depth--;
        end
        default: add_item(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                          random_value());
      endcase
    end
    if ($urandom_range(0, 3) != 0)
      repeat (depth) append_byte({TAG_END_COLLECTION, TYPE_MAIN, 2'd0});
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, desc_q.size());
      while (desc_q.size() > cut) void'(desc_q.pop_back());
    end
  endfunction

  function automatic void build_noise_descriptor();
    int n;
    n = $urandom_range(1, 30);
    desc_q.delete();
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // One descriptor with a stray End Collection, four-byte data, a usage of
  // all ones, saturating size and count, the largest product and an ignored
  // reserved-type item carrying the last flag.
  task automatic test_directed_items();
    desc_q = '{8'hC0,
               8'h07, 8'h34, 8'h12, 8'hFF, 8'hFF,
               8'h0A, 8'hFF, 8'hFF,
               8'hA1, 8'h01,
               8'h77, 8'h00, 8'h00, 8'h01, 8'h00,
               8'h97, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'h81, 8'h02,
               8'hC0,
               8'hFC};
    send_descriptor();
  endtask

  // An empty descriptor, one that ends on a prefix still waiting for data,
  // and one that ends inside an item with the outer of two collections open,
  // after a long-item prefix and a Push.
  task automatic test_cut_and_empty_descriptors();
    desc_q = '{8'h00};
    send_descriptor();
    desc_q = '{8'h06};
    send_descriptor();
    desc_q = '{8'hA0, 8'hA0, 8'hFE, 8'h02, 8'hAB, 8'hA4,
               8'h75, 8'h08, 8'h95, 8'h03, 8'h80, 8'hC0, 8'h26, 8'h11};
    send_descriptor();
  endtask

  // Nesting beyond 255 levels: the depth sticks at its ceiling, so the
  // record leaves early and the remaining End Collections are strays.
  task automatic test_depth_saturation();
    desc_q.delete();
    append_byte(8'h05);
    append_byte(8'($urandom_range(0, 255)));
    repeat (258) append_byte({TAG_COLLECTION, TYPE_MAIN, 2'd0});
    desc_q = {desc_q, 8'h75, 8'h04, 8'h95, 8'h03, 8'h81, 8'h00};
    repeat (258) append_byte({TAG_END_COLLECTION, TYPE_MAIN, 2'd0});
    append_byte(8'h00);
    send_descriptor();
  endtask

  // More than 255 top-level collections: the count sticks at 255 and the
  // record index at 254. The usage changes now and then along the way.
  task automatic test_collection_count_saturation();
    int i;
    desc_q.delete();
    for (i = 0; i < 260; i++) begin
      if (i % 16 == 0) begin
        append_byte(8'h09);
        append_byte(8'($urandom_range(0, 255)));
      end
      append_byte({TAG_COLLECTION, TYPE_MAIN, 2'd0});
      append_byte({TAG_END_COLLECTION, TYPE_MAIN, 2'd0});
    end
    send_descriptor();
  endtask

  // Random descriptors until the byte goal is met. Each descriptor draws
  // whether either side idles, which leaves stretches at full rate.
  task automatic test_random_descriptors();
    while (bytes_sent < BYTE_GOAL) begin
      snd_idle = ($urandom_range(0, 3) != 0);
      rcv_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) build_noise_descriptor();
      else build_structured_descriptor();
      send_descriptor();
    end
  endtask

  initial begin
    clear_parser_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_items();
    test_cut_and_empty_descriptors();
    test_depth_saturation();
    test_collection_count_saturation();
    test_random_descriptors();
    s_tvalid <= 1'b0;

    // Drain: every prediction must be met, then nothing more may appear.
    while (expected_records.size() != 0) @(posedge clk);
    snd_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d descriptor bytes in %0d descriptors.", bytes_sent,
             descriptors_sent);
    $display("Compared %0d records, %0d of them summaries, with %0d errors.",
             records_checked, summaries_checked, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
